FILE: hdl/chol_pkg.sv
// shared types and constants of the cholesky factorizer
package chol_pkg;

  localparam int DATA_W    = 32;
  localparam int IDX_W     = 3;
  localparam int SIZE_W    = 4;
  localparam int ACC_W     = 64;
  localparam int MAG_W     = 62;
  localparam int SQ_STEPS  = 31;
  localparam int DIV_STEPS = 32;
  localparam int CNT_W     = 6;
  localparam int MAX_ORDER_DEF     = 8;
  localparam int FRACTION_BITS_DEF = 16;

  typedef enum logic [2:0] {
    RES_ZERO,
    RES_MAX,
    RES_MIN,
    RES_SQRT,
    RES_DIV
  } res_sel_e;

  typedef struct packed {
    logic              a_we;
    logic [IDX_W-1:0]  ld_row;
    logic [IDX_W-1:0]  ld_col;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic [IDX_W-1:0]  k;
    logic              rd_diag;
    logic              mul_en;
    logic              acc_clr;
    logic              acc_en;
    logic              rem_en;
    logic              mag_en;
    logic              sq_start;
    logic              sq_step;
    logic              dv_start;
    logic              dv_step;
    logic              res_en;
    res_sel_e          res_sel;
    logic              out_load;
    logic              err;
    logic              last;
  } cmd_t;

  typedef struct packed {
    logic r_nonpos;
    logic r_neg;
    logic r_ge_lim;
    logic r_le_nlim;
    logic d_nonpos;
    logic q_ovf;
    logic out_free;
  } sts_t;

endpackage

FILE: hdl/cholesky_factorizer.sv
// top level of the cholesky factorizer
// Takes an n x n matrix (n = matrix_size, 1..8) one signed fixed-point element per transfer
// in row-major order and, after the last element, returns the n*(n+1)/2 lower-triangle
// entries of the factor L row by row, tlast on the last one, tuser set once a non-positive
// pivot has been met. Input is not taken while a matrix is being factorized. Each entry
// runs a multiply-accumulate loop over its products, then, unless a limit or error case
// applies, a diagonal square root or an off-diagonal division, on shared one-bit-per-cycle
// units; an 8x8 matrix takes 64 load transfers, and the factorization waits while the
// output side stalls. Writing matrix_size drops a partly loaded matrix.
module cholesky_factorizer #(
  parameter int MAX_ORDER     = chol_pkg::MAX_ORDER_DEF,
  parameter int FRACTION_BITS = chol_pkg::FRACTION_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // a_value
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // l_value, row_index, col_index, zero fill
  output logic        m_axis_tuser,   // pivot_error
  output logic        m_axis_tlast
);

  logic [chol_pkg::SIZE_W-1:0] matrix_size_q;
  logic cfg_wr;
  chol_pkg::cmd_t cmd;
  chol_pkg::sts_t sts;
  logic [chol_pkg::DATA_W-1:0] l_value;
  logic [chol_pkg::IDX_W-1:0]  row_idx, col_idx;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
  assign prdata = (paddr[2] == 1'b0) ? {28'h0, matrix_size_q} : 32'h0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      matrix_size_q <= chol_pkg::SIZE_W'(MAX_ORDER);
    end else if (cfg_wr) begin
      matrix_size_q <= pwdata[chol_pkg::SIZE_W-1:0];
    end
  end

  chol_ctrl #(
    .MAX_ORDER(MAX_ORDER)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .matrix_size_i (matrix_size_q),
    .cfg_wr_i      (cfg_wr),
    .s_valid_i     (s_axis_tvalid),
    .s_ready_o     (s_axis_tready),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  chol_dp #(
    .MAX_ORDER     (MAX_ORDER),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .a_value_i (s_axis_tdata),
    .m_ready_i (m_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .l_value_o (l_value),
    .row_o     (row_idx),
    .col_o     (col_idx),
    .err_o     (m_axis_tuser),
    .last_o    (m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, col_idx, row_idx, l_value};

endmodule

FILE: hdl/chol_dp.sv
// datapath: matrix stores, multiply-accumulate, square root and divide units, output register
module chol_dp #(
  parameter int MAX_ORDER     = chol_pkg::MAX_ORDER_DEF,
  parameter int FRACTION_BITS = chol_pkg::FRACTION_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  chol_pkg::cmd_t              cmd_i,
  output chol_pkg::sts_t              sts_o,
  input  logic [chol_pkg::DATA_W-1:0] a_value_i,
  input  logic                        m_ready_i,
  output logic                        m_valid_o,
  output logic [chol_pkg::DATA_W-1:0] l_value_o,
  output logic [chol_pkg::IDX_W-1:0]  row_o,
  output logic [chol_pkg::IDX_W-1:0]  col_o,
  output logic                        err_o,
  output logic                        last_o
);

  localparam int DEPTH  = MAX_ORDER * MAX_ORDER;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic signed [chol_pkg::ACC_W-1:0] LIM =
    chol_pkg::ACC_W'(64'sd1 <<< (62 - FRACTION_BITS));

  logic signed [chol_pkg::DATA_W-1:0] a_mem [DEPTH];
  logic signed [chol_pkg::DATA_W-1:0] l_mem [DEPTH];

  logic signed [chol_pkg::DATA_W-1:0] a_rd_q, l_rd0_q, l_rd1_q;
  logic signed [2*chol_pkg::DATA_W-1:0] prod_q;
  logic signed [chol_pkg::ACC_W-1:0]  acc_q, r_q;
  logic signed [chol_pkg::DATA_W-1:0] d_q;
  logic [chol_pkg::MAG_W-1:0]         mag_q;
  logic [chol_pkg::MAG_W-1:0]         sq_rad_q;
  logic [32:0]                        sq_rem_q;
  logic [30:0]                        sq_root_q;
  logic [31:0]                        dv_rem_q, dv_num_q, dv_quo_q;
  logic [chol_pkg::DATA_W-1:0]        val_d, val_q;
  logic                               m_valid_q;
  logic [chol_pkg::DATA_W-1:0]        l_value_q;
  logic [chol_pkg::IDX_W-1:0]         row_q, col_q;
  logic                               err_q, last_q;

  logic [ADDR_W-1:0] wa_addr, rd0_addr, rd1_addr, a_addr;
  logic signed [chol_pkg::ACC_W-1:0]  r_abs;
  logic [34:0] sq_cand, sq_trial;
  logic [31:0] dv_cand;

  assign wa_addr  = ADDR_W'(32'(cmd_i.ld_row) * MAX_ORDER + 32'(cmd_i.ld_col));
  assign a_addr   = ADDR_W'(32'(cmd_i.row) * MAX_ORDER + 32'(cmd_i.col));
  assign rd0_addr = ADDR_W'(32'(cmd_i.row) * MAX_ORDER + 32'(cmd_i.k));
  assign rd1_addr = cmd_i.rd_diag ? ADDR_W'(32'(cmd_i.col) * MAX_ORDER + 32'(cmd_i.col))
                                  : ADDR_W'(32'(cmd_i.col) * MAX_ORDER + 32'(cmd_i.k));

  always_ff @(posedge clk_i) begin
    if (cmd_i.a_we) begin
      a_mem[wa_addr] <= a_value_i;
    end
    a_rd_q <= a_mem[a_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_en) begin
      l_mem[a_addr] <= val_d;
    end
    l_rd0_q <= l_mem[rd0_addr];
    l_rd1_q <= l_mem[rd1_addr];
  end

  assign r_abs = r_q[chol_pkg::ACC_W-1] ? -r_q : r_q;

  // accumulate, remainder and magnitude
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= l_rd0_q * l_rd1_q;
    end
    if (cmd_i.acc_clr) begin
      acc_q <= '0;
    end else if (cmd_i.acc_en) begin
      acc_q <= acc_q + (prod_q >>> FRACTION_BITS);
    end
    if (cmd_i.rem_en) begin
      r_q <= chol_pkg::ACC_W'(a_rd_q) - acc_q;
      d_q <= l_rd1_q;
    end
    if (cmd_i.mag_en) begin
      mag_q <= chol_pkg::MAG_W'(r_abs <<< FRACTION_BITS);
    end
  end

  // square root, two radicand bits a step
  assign sq_cand  = {sq_rem_q[32:0], sq_rad_q[chol_pkg::MAG_W-1 -: 2]};
  assign sq_trial = {2'b00, sq_root_q, 2'b01};

  always_ff @(posedge clk_i) begin
    if (cmd_i.sq_start) begin
      sq_rad_q  <= mag_q;
      sq_rem_q  <= '0;
      sq_root_q <= '0;
    end else if (cmd_i.sq_step) begin
      sq_rad_q <= {sq_rad_q[chol_pkg::MAG_W-3:0], 2'b00};
      if (sq_cand >= sq_trial) begin
        sq_rem_q  <= 33'(sq_cand - sq_trial);
        sq_root_q <= {sq_root_q[29:0], 1'b1};
      end else begin
        sq_rem_q  <= 33'(sq_cand);
        sq_root_q <= {sq_root_q[29:0], 1'b0};
      end
    end
  end

  // restoring divide, one quotient bit a step
  assign dv_cand = {dv_rem_q[30:0], dv_num_q[31]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.dv_start) begin
      dv_rem_q <= 32'(mag_q[chol_pkg::MAG_W-1:32]);
      dv_num_q <= mag_q[31:0];
      dv_quo_q <= '0;
    end else if (cmd_i.dv_step) begin
      dv_num_q <= {dv_num_q[30:0], 1'b0};
      if (dv_cand >= 32'(d_q)) begin
        dv_rem_q <= dv_cand - 32'(d_q);
        dv_quo_q <= {dv_quo_q[30:0], 1'b1};
      end else begin
        dv_rem_q <= dv_cand;
        dv_quo_q <= {dv_quo_q[30:0], 1'b0};
      end
    end
  end

  always_comb begin
    case (cmd_i.res_sel)
      chol_pkg::RES_ZERO: val_d = '0;
      chol_pkg::RES_MAX:  val_d = 32'h7fff_ffff;
      chol_pkg::RES_MIN:  val_d = 32'h8000_0000;
      chol_pkg::RES_SQRT: val_d = {1'b0, sq_root_q};
      chol_pkg::RES_DIV: begin
        if (r_q[chol_pkg::ACC_W-1]) begin
          val_d = dv_quo_q[31] ? 32'h8000_0000 : -dv_quo_q;
        end else begin
          val_d = dv_quo_q[31] ? 32'h7fff_ffff : dv_quo_q;
        end
      end
      default: val_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_en) begin
      val_q <= val_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_ready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      l_value_q <= val_q;
      row_q     <= cmd_i.row;
      col_q     <= cmd_i.col;
      err_q     <= cmd_i.err;
      last_q    <= cmd_i.last;
    end
  end

  assign sts_o.r_nonpos  = (r_q <= 0);
  assign sts_o.r_neg     = r_q[chol_pkg::ACC_W-1];
  assign sts_o.r_ge_lim  = (r_q >= LIM);
  assign sts_o.r_le_nlim = (r_q <= -LIM);
  assign sts_o.d_nonpos  = (d_q <= 0);
  assign sts_o.q_ovf     = ({2'b00, mag_q} >= {d_q, 32'h0});
  assign sts_o.out_free  = !m_valid_q || m_ready_i;

  assign m_valid_o = m_valid_q;
  assign l_value_o = l_value_q;
  assign row_o     = row_q;
  assign col_o     = col_q;
  assign err_o     = err_q;
  assign last_o    = last_q;

endmodule

FILE: hdl/chol_ctrl.sv
// controller: load counters, entry sequencing and unit control
module chol_ctrl #(
  parameter int MAX_ORDER = chol_pkg::MAX_ORDER_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [chol_pkg::SIZE_W-1:0] matrix_size_i,
  input  logic                        cfg_wr_i,
  input  logic                        s_valid_i,
  output logic                        s_ready_o,
  input  chol_pkg::sts_t              sts_i,
  output chol_pkg::cmd_t              cmd_o
);

  localparam logic [3:0] S_LOAD  = 4'd0;
  localparam logic [3:0] S_ENTRY = 4'd1;
  localparam logic [3:0] S_RD    = 4'd2;
  localparam logic [3:0] S_MUL   = 4'd3;
  localparam logic [3:0] S_ACC   = 4'd4;
  localparam logic [3:0] S_AREAD = 4'd5;
  localparam logic [3:0] S_REM   = 4'd6;
  localparam logic [3:0] S_MAG   = 4'd7;
  localparam logic [3:0] S_CHECK = 4'd8;
  localparam logic [3:0] S_SQRT  = 4'd9;
  localparam logic [3:0] S_DIV   = 4'd10;
  localparam logic [3:0] S_FIN   = 4'd11;
  localparam logic [3:0] S_EMIT  = 4'd12;

  logic [3:0] state_q, state_d;
  logic [chol_pkg::IDX_W-1:0] ld_row_q, ld_row_d, ld_col_q, ld_col_d;
  logic [chol_pkg::IDX_W-1:0] i_q, i_d, j_q, j_d, k_q, k_d;
  logic [chol_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic err_q, err_d;
  chol_pkg::res_sel_e sel_q, sel_d;
  logic [chol_pkg::IDX_W-1:0] last_idx;
  logic s_fire, is_last;

  always_comb begin
    if (matrix_size_i == '0) begin
      last_idx = '0;
    end else if (32'(matrix_size_i) > MAX_ORDER) begin
      last_idx = chol_pkg::IDX_W'(MAX_ORDER - 1);
    end else begin
      last_idx = chol_pkg::IDX_W'(matrix_size_i - 1'b1);
    end
  end

  assign s_ready_o = (state_q == S_LOAD);
  assign s_fire    = s_valid_i && s_ready_o;
  assign is_last   = (i_q == last_idx) && (j_q == last_idx);

  always_comb begin
    state_d  = state_q;
    ld_row_d = ld_row_q;
    ld_col_d = ld_col_q;
    i_d      = i_q;
    j_d      = j_q;
    k_d      = k_q;
    cnt_d    = cnt_q;
    err_d    = err_q;
    sel_d    = sel_q;
    cmd_o          = '0;
    cmd_o.ld_row   = ld_row_q;
    cmd_o.ld_col   = ld_col_q;
    cmd_o.row      = i_q;
    cmd_o.col      = j_q;
    cmd_o.k        = k_q;
    cmd_o.res_sel  = sel_q;
    cmd_o.err      = err_q;
    cmd_o.last     = is_last;

    case (state_q)
      S_LOAD: begin
        if (cfg_wr_i) begin
          ld_row_d = '0;
          ld_col_d = '0;
          err_d    = 1'b0;
        end else if (s_fire) begin
          cmd_o.a_we = 1'b1;
          if (ld_col_q == last_idx) begin
            ld_col_d = '0;
            if (ld_row_q == last_idx) begin
              ld_row_d = '0;
              i_d      = '0;
              j_d      = '0;
              state_d  = S_ENTRY;
            end else begin
              ld_row_d = ld_row_q + 1'b1;
            end
          end else begin
            ld_col_d = ld_col_q + 1'b1;
          end
        end
      end
      S_ENTRY: begin
        cmd_o.acc_clr = 1'b1;
        k_d = '0;
        if (err_q) begin
          sel_d   = chol_pkg::RES_ZERO;
          state_d = S_FIN;
        end else if (j_q == '0) begin
          state_d = S_AREAD;
        end else begin
          state_d = S_RD;
        end
      end
      S_RD: state_d = S_MUL;
      S_MUL: begin
        cmd_o.mul_en = 1'b1;
        state_d = S_ACC;
      end
      S_ACC: begin
        cmd_o.acc_en = 1'b1;
        if (k_q + 1'b1 == j_q) begin
          state_d = S_AREAD;
        end else begin
          k_d     = k_q + 1'b1;
          state_d = S_RD;
        end
      end
      S_AREAD: begin
        cmd_o.rd_diag = 1'b1;
        state_d = S_REM;
      end
      S_REM: begin
        cmd_o.rem_en = 1'b1;
        state_d = S_MAG;
      end
      S_MAG: begin
        cmd_o.mag_en = 1'b1;
        state_d = S_CHECK;
      end
      S_CHECK: begin
        state_d = S_FIN;
        cnt_d   = '0;
        if (i_q == j_q) begin
          if (sts_i.r_nonpos) begin
            err_d = 1'b1;
            sel_d = chol_pkg::RES_ZERO;
          end else if (sts_i.r_ge_lim) begin
            sel_d = chol_pkg::RES_MAX;
          end else begin
            cmd_o.sq_start = 1'b1;
            sel_d   = chol_pkg::RES_SQRT;
            state_d = S_SQRT;
          end
        end else begin
          if (sts_i.d_nonpos) begin
            sel_d = chol_pkg::RES_ZERO;
          end else if (sts_i.r_ge_lim) begin
            sel_d = chol_pkg::RES_MAX;
          end else if (sts_i.r_le_nlim) begin
            sel_d = chol_pkg::RES_MIN;
          end else if (sts_i.q_ovf) begin
            sel_d = sts_i.r_neg ? chol_pkg::RES_MIN : chol_pkg::RES_MAX;
          end else begin
            cmd_o.dv_start = 1'b1;
            sel_d   = chol_pkg::RES_DIV;
            state_d = S_DIV;
          end
        end
      end
      S_SQRT: begin
        cmd_o.sq_step = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == chol_pkg::CNT_W'(chol_pkg::SQ_STEPS - 1)) begin
          state_d = S_FIN;
        end
      end
      S_DIV: begin
        cmd_o.dv_step = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == chol_pkg::CNT_W'(chol_pkg::DIV_STEPS - 1)) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        cmd_o.res_en = 1'b1;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          if (is_last) begin
            err_d   = 1'b0;
            state_d = S_LOAD;
          end else begin
            if (j_q == i_q) begin
              i_d = i_q + 1'b1;
              j_d = '0;
            end else begin
              j_d = j_q + 1'b1;
            end
            state_d = S_ENTRY;
          end
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_LOAD;
      ld_row_q <= '0;
      ld_col_q <= '0;
      i_q      <= '0;
      j_q      <= '0;
      k_q      <= '0;
      cnt_q    <= '0;
      err_q    <= 1'b0;
      sel_q    <= chol_pkg::RES_ZERO;
    end else begin
      state_q  <= state_d;
      ld_row_q <= ld_row_d;
      ld_col_q <= ld_col_d;
      i_q      <= i_d;
      j_q      <= j_d;
      k_q      <= k_d;
      cnt_q    <= cnt_d;
      err_q    <= err_d;
      sel_q    <= sel_d;
    end
  end

  a_col_le_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_LOAD) |-> (j_q <= i_q))
    else $error("column above row during factorization");

  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (err_q && state_q != S_EMIT && state_q != S_LOAD) |=> err_q)
    else $error("pivot error cleared inside a matrix");

  a_sqrt_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SQRT) |=> (state_q == S_SQRT || state_q == S_FIN))
    else $error("square root left early");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> sts_i.out_free)
    else $error("output register overwritten");

endmodule
